// ----- src/dmwc_pkg.sv -----
package dmwc_pkg;

  localparam int ADDR_W     = 14;
  localparam int BYTE_W     = 8;
  localparam int OFF_W      = 2;
  localparam int WADDR_W    = ADDR_W - OFF_W;
  localparam int WORD_W     = 32;
  localparam int CNT_W      = 32;
  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 80;

  // field positions inside the result beat
  localparam int OUT_HIT_BIT  = BYTE_W;
  localparam int OUT_HTOT_LSB = BYTE_W + 1;
  localparam int OUT_MTOT_LSB = OUT_HTOT_LSB + CNT_W;
  localparam int OUT_USED_W   = OUT_MTOT_LSB + CNT_W;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam int DEF_LINES     = 64;
  localparam int DEF_MEM_WORDS = 4096;

  typedef struct packed {
    logic               op;
    logic [WADDR_W-1:0] word_addr;
    logic [OFF_W-1:0]   offset;
    logic [BYTE_W-1:0]  wbyte;
  } cmd_t;

endpackage

// ----- src/direct_mapped_writeback_cache_unit.sv -----
// channel  direction  ports                       beat contents (low bit first)
// in       slave      in_tvalid/tready/tdata/tuser  tdata: address, write_byte; tuser: operation
// out      master     out_tvalid/tready/tdata       read_byte, was_hit, hit_total, miss_total
//
// in the back end a hit goes through line lookup, then merge and result; a miss through
// line lookup, write-back of a dirty line with the backing word read, then merge and result
// after reset the backing store and line valid bits are swept to zero, one entry a
// cycle over max(LINES, MEM_WORDS) entries, with in_tready low throughout
// a two-entry command queue lets the input side keep taking beats while the back end
// works; a result waiting on out_tready holds the back end, and input once the queue is full
module direct_mapped_writeback_cache_unit import dmwc_pkg::*; #(
  parameter int LINES     = DEF_LINES,
  parameter int MEM_WORDS = DEF_MEM_WORDS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // address[13:0], write_byte[21:14], zero pad
  input  logic [IN_USER_W-1:0]  in_tuser,   // operation[0]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // read_byte[7:0], was_hit[8],
                                            // hit_total[40:9], miss_total[72:41], zero pad
);

  logic clear_busy;
  logic q_push, q_full, q_pop, q_valid;
  cmd_t q_push_cmd, q_head_cmd;

  dmwc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept_en  (!clear_busy),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_push_cmd (q_push_cmd)
  );

  dmwc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_cmd   (q_push_cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_cmd   (q_head_cmd)
  );

  dmwc_back #(
    .LINES     (LINES),
    .MEM_WORDS (MEM_WORDS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_cmd      (q_head_cmd),
    .q_pop      (q_pop),
    .clear_busy (clear_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // nothing enters while the sweep runs
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> !in_tready)
    else $error("input beat taken during clear sweep");

  // no result can exist before the sweep ends
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_busy |-> !out_tvalid)
    else $error("result beat during clear sweep");

  // the queue only feeds the back end when it holds a command
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid && !clear_busy)
    else $error("queue popped while empty or clearing");

endmodule

// ----- src/dmwc_front.sv -----
module dmwc_front import dmwc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept_en,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,   // address[13:0], write_byte[21:14], zero pad
  input  logic [IN_USER_W-1:0] in_tuser,   // operation[0]
  input  logic                 q_full,
  output logic                 q_push,
  output cmd_t                 q_push_cmd
);

  logic cmd_valid_r, cmd_valid_nxt;
  cmd_t cmd_r;
  logic take;
  cmd_t dec;

  always_comb begin
    dec.op        = in_tuser[0];
    dec.word_addr = in_tdata[ADDR_W-1:OFF_W];
    dec.offset    = in_tdata[OFF_W-1:0];
    // reads carry no byte
    dec.wbyte     = (in_tuser[0] == OP_WRITE) ? in_tdata[ADDR_W+BYTE_W-1:ADDR_W] : '0;
  end

  assign q_push     = cmd_valid_r && !q_full;
  assign q_push_cmd = cmd_r;
  assign in_tready  = accept_en && (!cmd_valid_r || !q_full);
  assign take       = in_tvalid && in_tready;

  always_comb begin
    cmd_valid_nxt = cmd_valid_r;
    if (take) begin
      cmd_valid_nxt = 1'b1;
    end else if (q_push) begin
      cmd_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= dec;
    end
  end

endmodule

// ----- src/dmwc_queue.sv -----
module dmwc_queue import dmwc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t              ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- src/dmwc_back.sv -----
module dmwc_back import dmwc_pkg::*; #(
  parameter int LINES     = DEF_LINES,
  parameter int MEM_WORDS = DEF_MEM_WORDS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  cmd_t                  q_cmd,
  output logic                  q_pop,
  output logic                  clear_busy,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int IDX_W   = $clog2(LINES);
  localparam int TAG_W   = (WADDR_W > IDX_W) ? (WADDR_W - IDX_W) : 1;
  localparam int MEM_AW  = $clog2(MEM_WORDS);
  localparam int CLR_LEN = (LINES > MEM_WORDS) ? LINES : MEM_WORDS;
  localparam int CLR_W   = $clog2(CLR_LEN);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;
  localparam logic [1:0] ST_FILL  = 2'd3;

  // line stores and backing store, one write and one registered read each
  logic [TAG_W-1:0]  tag_mem  [LINES];
  logic [1:0]        vd_mem   [LINES];   // {valid, dirty}
  logic [WORD_W-1:0] word_mem [LINES];
  logic [WORD_W-1:0] back_mem [MEM_WORDS];

  logic [1:0]        st_r, st_nxt;
  logic [CLR_W-1:0]  clr_r, clr_nxt;
  cmd_t              cur_r;
  logic [CNT_W-1:0]  hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0]  miss_cnt_r, miss_cnt_nxt;
  logic              fwd_r;
  logic [WORD_W-1:0] fwd_word_r;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [TAG_W-1:0]  tag_q;
  logic [1:0]        vd_q;
  logic [WORD_W-1:0] word_q;
  logic [WORD_W-1:0] back_q;

  logic [IDX_W-1:0]  cur_idx, rd_idx;
  logic [TAG_W-1:0]  cur_tag;
  logic [MEM_AW-1:0] old_slot, new_slot;
  logic              hit, out_free, finish, wb_go;
  logic [WORD_W-1:0] line_in, merged;
  logic [BYTE_W-1:0] rbyte;
  logic [4:0]        bit_pos;

  logic              line_we;
  logic              vd_we;
  logic [IDX_W-1:0]  vd_wa;
  logic [1:0]        vd_wd;
  logic              bk_we;
  logic [MEM_AW-1:0] bk_wa;
  logic [WORD_W-1:0] bk_wd;
  logic              clr_mem_en, clr_line_en;

  assign cur_idx  = cur_r.word_addr[IDX_W-1:0];
  assign cur_tag  = TAG_W'(cur_r.word_addr >> IDX_W);
  assign rd_idx   = (st_r == ST_IDLE) ? q_cmd.word_addr[IDX_W-1:0] : cur_idx;
  assign old_slot = MEM_AW'({tag_q, cur_idx});
  assign new_slot = MEM_AW'(cur_r.word_addr);

  assign hit      = vd_q[1] && (tag_q == cur_tag);
  assign out_free = !out_valid_r || out_tready;
  assign finish   = ((st_r == ST_LOOK) && hit && out_free) ||
                    ((st_r == ST_FILL) && out_free);
  assign wb_go    = (st_r == ST_LOOK) && !hit && vd_q[0];
  assign q_pop    = (st_r == ST_IDLE) && q_valid;
  assign clear_busy = (st_r == ST_CLEAR);

  assign clr_mem_en  = ({1'b0, clr_r} < (CLR_W + 1)'(MEM_WORDS));
  assign clr_line_en = ({1'b0, clr_r} < (CLR_W + 1)'(LINES));

  always_comb begin
    if (st_r == ST_FILL) begin
      line_in = fwd_r ? fwd_word_r : back_q;
    end else begin
      line_in = word_q;
    end
    bit_pos = {cur_r.offset, 3'b000};
    merged  = line_in;
    if (cur_r.op == OP_WRITE) begin
      merged[bit_pos +: BYTE_W] = cur_r.wbyte;
    end
    rbyte = (cur_r.op == OP_WRITE) ? '0 : line_in[bit_pos +: BYTE_W];
  end

  always_comb begin
    line_we = finish;
    vd_we   = 1'b0;
    vd_wa   = cur_idx;
    // a hit keeps the dirty bit, a fill starts clean, and a write sets it
    vd_wd   = {1'b1, (cur_r.op == OP_WRITE) || ((st_r == ST_LOOK) && vd_q[0])};
    bk_we   = 1'b0;
    bk_wa   = old_slot;
    bk_wd   = word_q;
    if (st_r == ST_CLEAR) begin
      vd_we = clr_line_en;
      vd_wa = clr_r[IDX_W-1:0];
      vd_wd = 2'b00;
      bk_we = clr_mem_en;
      bk_wa = clr_r[MEM_AW-1:0];
      bk_wd = '0;
    end else begin
      vd_we = finish;
      bk_we = wb_go;
    end
  end

  always_comb begin
    st_nxt        = st_r;
    clr_nxt       = clr_r;
    hit_cnt_nxt   = hit_cnt_r;
    miss_cnt_nxt  = miss_cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (st_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CLR_W'(CLR_LEN - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          st_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (!hit) begin
          st_nxt = ST_FILL;
        end else if (out_free) begin
          hit_cnt_nxt   = hit_cnt_r + 1'b1;
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      ST_FILL: begin
        if (out_free) begin
          miss_cnt_nxt  = miss_cnt_r + 1'b1;
          out_valid_nxt = 1'b1;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_r       <= '0;
      hit_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_r       <= clr_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      miss_cnt_r  <= miss_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_cmd;
    end
    if (st_r == ST_LOOK) begin
      // write-back and fill hit the same backing word when the store wraps
      fwd_r      <= wb_go && (old_slot == new_slot);
      fwd_word_r <= word_q;
    end
    if (finish) begin
      out_data_r <= OUT_DATA_W'({miss_cnt_nxt, hit_cnt_nxt, hit, rbyte});
    end
  end

  always_ff @(posedge clk) begin
    tag_q  <= tag_mem[rd_idx];
    word_q <= word_mem[rd_idx];
    if (line_we) begin
      tag_mem[cur_idx]  <= cur_tag;
      word_mem[cur_idx] <= merged;
    end
  end

  always_ff @(posedge clk) begin
    vd_q <= vd_mem[rd_idx];
    if (vd_we) begin
      vd_mem[vd_wa] <= vd_wd;
    end
  end

  always_ff @(posedge clk) begin
    back_q <= back_mem[new_slot];
    if (bk_we) begin
      back_mem[bk_wa] <= bk_wd;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- tb/sv/tb_direct_mapped_writeback_cache_unit.sv -----
`timescale 1ns / 1ps

module tb_direct_mapped_writeback_cache_unit;
  import dmwc_pkg::*;

  localparam int IDX_W    = 6;
  localparam int TAG_W    = WADDR_W - IDX_W;
  localparam int N_RANDOM = 2000;

  typedef struct {
    bit [BYTE_W-1:0] read_byte;
    bit              was_hit;
    bit [CNT_W-1:0]  hit_total;
    bit [CNT_W-1:0]  miss_total;
  } access_result_t;

  // mirror of the cache and its backing store, one expected result per access
  class cache_mirror;
    bit [TAG_W-1:0]  line_tag [1 << IDX_W];
    bit              line_valid [1 << IDX_W];
    bit              line_dirty [1 << IDX_W];
    bit [WORD_W-1:0] line_word [1 << IDX_W];
    bit [WORD_W-1:0] backing [1 << WADDR_W];
    bit [CNT_W-1:0]  hits;
    bit [CNT_W-1:0]  misses;
    access_result_t  pending_results[$];
    int              fails;
    int              checked;
    int              writebacks;
    int              writes;

    function void note_access(logic op, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] wb);
      logic [WADDR_W-1:0] waddr;
      logic [IDX_W-1:0]   idx;
      logic [TAG_W-1:0]   tg;
      int                 shift;
      access_result_t     r;
      waddr = addr[ADDR_W-1:OFF_W];
      idx   = waddr[IDX_W-1:0];
      tg    = waddr[WADDR_W-1:IDX_W];
      shift = addr[OFF_W-1:0] * 8;
      r = '{default: '0};
      r.was_hit = line_valid[idx] && (line_tag[idx] == tg);
      if (r.was_hit) begin
        hits++;
      end else begin
        misses++;
        if (line_dirty[idx]) begin
          backing[{line_tag[idx], idx}] = line_word[idx];
          writebacks++;
        end
        line_tag[idx]   = tg;
        line_word[idx]  = backing[waddr];
        line_valid[idx] = 1'b1;
        line_dirty[idx] = 1'b0;
      end
      if (op == OP_WRITE) begin
        line_word[idx][shift +: BYTE_W] = wb;
        line_dirty[idx] = 1'b1;
        writes++;
      end else begin
        r.read_byte = line_word[idx][shift +: BYTE_W];
      end
      r.hit_total  = hits;
      r.miss_total = misses;
      pending_results.push_back(r);
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] beat);
      access_result_t want;
      if (pending_results.size() == 0) begin
        $error("result beat with no access outstanding: %h", beat);
        fails++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (beat[BYTE_W-1:0] !== want.read_byte) begin
        $error("read_byte: expected %h, got %h", want.read_byte, beat[BYTE_W-1:0]);
        fails++;
      end
      if (beat[OUT_HIT_BIT] !== want.was_hit) begin
        $error("was_hit: expected %0d, got %0d", want.was_hit, beat[OUT_HIT_BIT]);
        fails++;
      end
      if (beat[OUT_HTOT_LSB +: CNT_W] !== want.hit_total) begin
        $error("hit_total: expected %0d, got %0d", want.hit_total,
               beat[OUT_HTOT_LSB +: CNT_W]);
        fails++;
      end
      if (beat[OUT_MTOT_LSB +: CNT_W] !== want.miss_total) begin
        $error("miss_total: expected %0d, got %0d", want.miss_total,
               beat[OUT_MTOT_LSB +: CNT_W]);
        fails++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  cache_mirror mirror = new;
  bit          quiet;

  always #2 clk = ~clk;

  direct_mapped_writeback_cache_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      mirror.note_access(in_tuser[0], in_tdata[ADDR_W-1:0], in_tdata[ADDR_W +: BYTE_W]);
    if (rst_n && out_tvalid && out_tready)
      mirror.check_result(out_tdata);
  end

  // result side stalls now and then
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= quiet || ($urandom_range(0, 99) >= 17);
    end
  end

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_access(logic op, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] wb);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[ADDR_W-1:0] = addr;
    d[ADDR_W +: BYTE_W] = wb;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (!quiet && $urandom_range(0, 99) < 17) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (mirror.pending_results.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [TAG_W-1:0] work_tags [2];
    logic [TAG_W-1:0] tg;
    logic [IDX_W-1:0] idx;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    rst_n     = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // read miss on a clean line, then writes into it at both ends of the word
    send_access(OP_READ,  14'h0000, 8'h00);
    send_access(OP_WRITE, 14'h0000, 8'hff);
    send_access(OP_WRITE, 14'h0003, 8'ha5);
    send_access(OP_READ,  14'h0000, 8'h00);
    send_access(OP_READ,  14'h0003, 8'h00);
    // conflicting tag forces a write-back, then the old word comes back in
    send_access(OP_READ,  14'h0100, 8'hff);
    send_access(OP_READ,  14'h0000, 8'h00);
    send_access(OP_READ,  14'h0003, 8'h00);
    // write miss at the top of the address space, every byte lane
    send_access(OP_WRITE, 14'h3fff, 8'hff);
    send_access(OP_WRITE, 14'h3ffe, 8'h00);
    send_access(OP_WRITE, 14'h3ffd, 8'h5a);
    send_access(OP_WRITE, 14'h3ffc, 8'h3c);
    send_access(OP_READ,  14'h3fff, 8'h00);
    send_access(OP_READ,  14'h3ffd, 8'h00);
    send_access(OP_READ,  14'h3ffe, 8'h00);
    // write miss over a dirty victim, then both words read back
    send_access(OP_WRITE, 14'h00ff, 8'h81);
    send_access(OP_READ,  14'h3ffc, 8'h00);
    send_access(OP_READ,  14'h00ff, 8'h00);
    send_access(OP_WRITE, 14'h0101, 8'h7e);
    send_access(OP_READ,  14'h0101, 8'hff);
    send_access(OP_READ,  14'h0002, 8'h00);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 250 == 0) begin
        work_tags[0] = TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
        work_tags[1] = TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
      end
      quiet = (n >= 400 && n < 800);
      if (n == 1000)
        drain();
      // mostly a pair of tags over a few lines so hits and dirty evictions are common
      if ($urandom_range(0, 99) < 80)
        tg = work_tags[$urandom_range(0, 1)];
      else
        tg = TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
      if ($urandom_range(0, 99) < 60)
        idx = IDX_W'($urandom_range(0, 15));
      else
        idx = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
      send_access(1'($urandom_range(0, 1)), {tg, idx, OFF_W'($urandom_range(0, 3))},
                  BYTE_W'($urandom_range(0, 255)));
      maybe_gap();
    end

    drain();
    repeat (20) @(negedge clk);
    $display("checked %0d accesses (%0d writes): %0d hits, %0d misses",
             mirror.checked, mirror.writes, mirror.hits, mirror.misses);
    $display("%0d dirty lines written back to the backing store", mirror.writebacks);
    if (mirror.fails == 0 && mirror.pending_results.size() == 0) begin
      $display("direct_mapped_writeback_cache_unit: match");
    end else begin
      $display("direct_mapped_writeback_cache_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("direct_mapped_writeback_cache_unit: mismatch");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/dmwc_pkg.sv
src/dmwc_front.sv
src/dmwc_queue.sv
src/dmwc_back.sv
src/direct_mapped_writeback_cache_unit.sv
tb/sv/tb_direct_mapped_writeback_cache_unit.sv
